[rtl/core/assert_macros.svh]
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/ufd_pkg.sv]
// types and constants for the utf-8 stream decoder
package ufd_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;
  localparam int LEN_W  = 3;
  localparam int PEND_W = 2;
  localparam int ERR_W  = 2;
  localparam int PAYLOAD_BITS = 6;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_LEAD  = 2'd1,
    ERR_CONT  = 2'd2,
    ERR_TRUNC = 2'd3
  } err_kind_t;

  typedef struct packed {
    logic [PEND_W-1:0] pending;
    logic [CP_W-1:0]   partial;
    logic [LEN_W-1:0]  total;
  } dec_state_t;

  typedef struct packed {
    logic              valid;
    logic [CP_W-1:0]   code_point;
    logic [LEN_W-1:0]  seq_length;
    err_kind_t         error_kind;
    logic              stream_end;
  } dec_result_t;

endpackage

[rtl/core/utf8_stream_decoder_unit.sv]
// utf-8 stream decoder top level
// usage:
//   input channel: one byte per transfer on in_byte_in, with in_last_byte
//   high on the final byte of a string. the next byte starts a new string.
//   result channel: at most one result per byte, carrying code point,
//   sequence length, error kind and the stream end flag of its byte.
//   lead bytes of multi-byte sequences and inner continuation bytes give
//   no result; errors give one result with code point and length zero.
// path: the byte that causes a result passes the input register, then
//   the result register, before the result appears on the out_ ports.
// throughput: one byte per cycle unless a stalled result holds it, set
//   by the single decode stage between the input and result registers.
// reset: synchronous, active low; clears both stages and returns the
//   decoder to idle, awaiting a lead byte.
// stall: while out_stall holds a result, a byte that would give a result
//   waits in the input register and in_stall rises; bytes that give no
//   result keep moving.
module utf8_stream_decoder_unit
  import ufd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_byte_in,
  input  logic              in_last_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CP_W-1:0]   out_code_point,
  output logic [LEN_W-1:0]  out_seq_length,
  output logic [ERR_W-1:0]  out_error_kind,
  output logic              out_stream_end
);

  logic              a_valid_r;
  logic              a_valid_nxt;
  logic [BYTE_W-1:0] a_byte_r;
  logic              a_last_r;
  dec_state_t        state_r;
  dec_state_t        state_nxt;
  dec_result_t       res;
  dec_result_t       res_r;
  logic              out_free;
  logic              a_consume;
  logic              in_xfer;

  ufd_decode u_decode (
    .byte_in   (a_byte_r),
    .last_byte (a_last_r),
    .cur       (state_r),
    .nxt       (state_nxt),
    .res       (res)
  );

  assign out_free  = !res_r.valid || !out_stall;
  assign a_consume = a_valid_r && (!res.valid || out_free);
  assign in_stall  = a_valid_r && !a_consume;
  assign in_xfer   = in_valid && !in_stall;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_xfer) begin
      a_valid_nxt = 1'b1;
    end else if (a_consume) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_byte_r <= in_byte_in;
      a_last_r <= in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (a_consume) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.valid <= 1'b0;
    end else if (out_free) begin
      res_r.valid <= a_consume && res.valid;
      if (a_consume && res.valid) begin
        res_r.code_point <= res.code_point;
        res_r.seq_length <= res.seq_length;
        res_r.error_kind <= res.error_kind;
        res_r.stream_end <= res.stream_end;
      end
    end
  end

  assign out_valid      = res_r.valid;
  assign out_code_point = res_r.code_point;
  assign out_seq_length = res_r.seq_length;
  assign out_error_kind = res_r.error_kind;
  assign out_stream_end = res_r.stream_end;

endmodule

[rtl/core/ufd_decode.sv]
// per-byte decode logic: next decoder state and result from one byte
module ufd_decode
  import ufd_pkg::*;
(
  input  logic [BYTE_W-1:0] byte_in,
  input  logic              last_byte,
  input  dec_state_t        cur,
  output dec_state_t        nxt,
  output dec_result_t       res
);

  localparam dec_state_t IDLE_STATE = '0;

  logic [CP_W-1:0]   shifted;
  logic [PEND_W-1:0] pend_dec;

  assign shifted  = {cur.partial[CP_W-PAYLOAD_BITS-1:0], byte_in[PAYLOAD_BITS-1:0]};
  assign pend_dec = cur.pending - PEND_W'(1);

  always_comb begin
    nxt = cur;
    res = '0;
    res.error_kind = ERR_NONE;
    res.stream_end = last_byte;
    if (cur.pending == '0) begin
      if (!byte_in[BYTE_W-1]) begin
        res.valid      = 1'b1;
        res.code_point = CP_W'(byte_in);
        res.seq_length = LEN_W'(1);
      end else if (byte_in inside {[8'hF0:8'hF7]}) begin
        nxt.pending = PEND_W'(3);
        nxt.partial = CP_W'(byte_in[2:0]);
        nxt.total   = LEN_W'(4);
      end else if (byte_in inside {[8'hE0:8'hEF]}) begin
        nxt.pending = PEND_W'(2);
        nxt.partial = CP_W'(byte_in[3:0]);
        nxt.total   = LEN_W'(3);
      end else if (byte_in inside {[8'hC0:8'hDF]}) begin
        nxt.pending = PEND_W'(1);
        nxt.partial = CP_W'(byte_in[4:0]);
        nxt.total   = LEN_W'(2);
      end else begin
        res.valid      = 1'b1;
        res.error_kind = ERR_LEAD;
      end
      // lead of a multi-byte sequence on the final byte
      if (byte_in[BYTE_W-1] && byte_in[BYTE_W-2] && !(byte_in inside {[8'hF8:8'hFF]})
          && last_byte) begin
        nxt            = IDLE_STATE;
        res.valid      = 1'b1;
        res.error_kind = ERR_TRUNC;
      end
    end else if (byte_in[7:6] != 2'b10) begin
      nxt            = IDLE_STATE;
      res.valid      = 1'b1;
      res.error_kind = ERR_CONT;
    end else if (pend_dec == '0) begin
      nxt            = IDLE_STATE;
      res.valid      = 1'b1;
      res.code_point = shifted;
      res.seq_length = cur.total;
    end else if (last_byte) begin
      nxt            = IDLE_STATE;
      res.valid      = 1'b1;
      res.error_kind = ERR_TRUNC;
    end else begin
      nxt.pending = pend_dec;
      nxt.partial = shifted;
    end
  end

endmodule

[rtl/core/ufd_checker.sv]
// port-level checker for the utf-8 stream decoder, bound to the top level
`include "assert_macros.svh"

module ufd_checker
  import ufd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CP_W-1:0]   out_code_point,
  input logic [LEN_W-1:0]  out_seq_length,
  input logic [ERR_W-1:0]  out_error_kind,
  input logic              out_stream_end
);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_code_point) && $stable(out_error_kind)
    && $stable(out_seq_length) && $stable(out_stream_end), "stalled result changed")

  `ASSERT_SAME(a_err_zero, clk, rst_n, out_valid && out_error_kind != ERR_NONE,
    out_code_point == '0 && out_seq_length == '0, "error result carries data")

  `ASSERT_SAME(a_ok_len, clk, rst_n, out_valid && out_error_kind == ERR_NONE,
    out_seq_length != '0 && out_seq_length < LEN_W'(5), "bad sequence length")

  `ASSERT_SAME(a_trunc_end, clk, rst_n, out_valid && out_error_kind == ERR_TRUNC,
    out_stream_end, "truncation without stream end")

  `ASSERT_SAME(a_ascii_range, clk, rst_n,
    out_valid && out_error_kind == ERR_NONE && out_seq_length == LEN_W'(1),
    out_code_point[CP_W-1:7] == '0, "single byte value out of range")

endmodule

bind utf8_stream_decoder_unit ufd_checker u_ufd_checker (.*);
